@@ rtl/core/tcce_pkg.sv @@
// ---------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the TCP client connection engine
// Field widths, operation, event and flag codes, the slot row layout and
// the segment builder used by the update stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcce_pkg;

	localparam int OP_W    = 2;
	localparam int SLOT_W  = 6;
	localparam int ISEQ_W  = 28;
	localparam int FLAG_W  = 6;
	localparam int SEQ_W   = 32;
	localparam int DLEN_W  = 16;
	localparam int PLEN_W  = 11;
	localparam int EV_W    = 3;
	localparam int CF_W    = 5;
	localparam int RC_W    = 8;
	localparam int CFG_W   = 11;
	localparam int CIDX_W  = 1;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_OPEN    = 2'd0;
	localparam logic [OP_W-1:0] OP_SEG     = 2'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

	// Event codes.
	localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
	localparam logic [EV_W-1:0] EV_INITIATED = 3'd1;
	localparam logic [EV_W-1:0] EV_COMPLETED = 3'd2;
	localparam logic [EV_W-1:0] EV_TIMED_OUT = 3'd3;
	localparam logic [EV_W-1:0] EV_RST_RECV  = 3'd4;
	localparam logic [EV_W-1:0] EV_RST_REPLY = 3'd5;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_REQUEST_LEN = 1'd0;
	localparam logic [CIDX_W-1:0] REG_MAX_RESENDS = 1'd1;

	// TCP header flags.
	localparam logic [FLAG_W-1:0] TH_FIN = 6'h01;
	localparam logic [FLAG_W-1:0] TH_SYN = 6'h02;
	localparam logic [FLAG_W-1:0] TH_RST = 6'h04;
	localparam logic [FLAG_W-1:0] TH_PSH = 6'h08;
	localparam logic [FLAG_W-1:0] TH_ACK = 6'h10;

	// Bit positions of the per-connection flags.
	localparam int CF_SEND   = 0;
	localparam int CF_CONN   = 1;
	localparam int CF_GFIN   = 2;
	localparam int CF_SFIN   = 3;
	localparam int CF_CLOSED = 4;

	localparam logic [RC_W-1:0] RC_MAX = 8'hff;

	// One connection table row.
	typedef struct packed {
		logic              active;
		logic [ISEQ_W-1:0] first_seq;
		logic [SEQ_W-1:0]  next_send_seq;
		logic [SEQ_W-1:0]  oldest_unacked;
		logic [SEQ_W-1:0]  next_recv_seq;
		logic [CF_W-1:0]   conn_flags;
		logic [RC_W-1:0]   resend_count;
	} row_t;

	// Registered input item.
	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic              in_range;
		logic [ISEQ_W-1:0] initial_seq;
		logic [FLAG_W-1:0] seg_flags;
		logic [SEQ_W-1:0]  seg_seq;
		logic [SEQ_W-1:0]  seg_ack;
		logic [DLEN_W-1:0] seg_data_len;
		logic [SEQ_W-1:0]  seg_end;
	} item_t;

	// One result item.
	typedef struct packed {
		logic              send_valid;
		logic [SEQ_W-1:0]  out_seq;
		logic [SEQ_W-1:0]  out_ack;
		logic [FLAG_W-1:0] out_flags;
		logic [PLEN_W-1:0] out_payload_len;
		logic [EV_W-1:0]   event_res;
		logic              slot_freed;
	} res_t;

	// Outcome of building a segment for one connection.
	typedef struct packed {
		logic              sent;
		logic [SEQ_W-1:0]  seq;
		logic [SEQ_W-1:0]  ack;
		logic [FLAG_W-1:0] flags;
		logic [PLEN_W-1:0] plen;
		logic [CF_W-1:0]   conn_flags;
		logic [SEQ_W-1:0]  next_send_seq;
	} emit_t;

	// Builds the next segment of a connection: SYN before the handshake,
	// the request with PSH and FIN while it is not acknowledged, else an
	// ACK, with FIN once the peer's FIN is taken, when one is pending.
	function automatic emit_t emit_seg(row_t r, logic [PLEN_W-1:0] req_len);
		emit_t            e;
		logic [SEQ_W-1:0] iss;
		logic [SEQ_W-1:0] unacked;
		logic             conn;
		logic             pay;
		logic [CF_W-1:0]  f;
		iss     = SEQ_W'(r.first_seq);
		unacked = r.oldest_unacked - iss - SEQ_W'(1);
		conn    = r.conn_flags[CF_CONN];
		pay     = conn && (unacked < SEQ_W'(req_len));
		f       = r.conn_flags;
		e       = '0;
		e.next_send_seq = r.next_send_seq;
		if (pay) begin
			e.plen          = req_len;
			e.seq           = iss + SEQ_W'(1);
			e.next_send_seq = iss + SEQ_W'(1) + SEQ_W'(req_len);
		end else begin
			e.seq = r.next_send_seq + SEQ_W'(f[CF_SFIN]);
		end
		e.sent = !(conn && !f[CF_SEND] && !pay);
		f[CF_SEND] = 1'b0;
		if (!conn) begin
			e.flags = TH_SYN;
		end else begin
			e.flags = TH_ACK;
			if (pay) begin
				e.flags = e.flags | TH_PSH | TH_FIN;
			end
			if (f[CF_GFIN]) begin
				e.flags = e.flags | TH_FIN;
			end
			e.ack = r.next_recv_seq;
		end
		if ((e.flags & TH_FIN) != '0) begin
			f[CF_SFIN] = 1'b1;
		end
		if (f[CF_SFIN] && f[CF_GFIN]) begin
			f[CF_CLOSED] = 1'b1;
		end
		e.conn_flags = f;
		return e;
	endfunction

endpackage

@@ rtl/core/tcce_table.sv @@
// ---------------------------------------------------------------------------
// tcce_table: connection table memory
// One row per slot, one write and one registered read per cycle. A read of
// the row written in the same cycle returns the new row. After reset a
// sweep clears the active bit of every row, one row per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_table #(
	parameter int NUM_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(NUM_SLOTS)-1:0] wr_idx,
	input  tcce_pkg::row_t               wr_row,
	input  logic                         rd_en,
	input  logic [$clog2(NUM_SLOTS)-1:0] rd_idx,
	output tcce_pkg::row_t               rd_row,
	output logic                         busy
);
	import tcce_pkg::*;

	localparam int IDX_W = $clog2(NUM_SLOTS);

	row_t             mem [NUM_SLOTS];
	row_t             rd_row_q;
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;

	// Clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == IDX_W'(NUM_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Row storage with write-first read.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= (wr_en && wr_idx == rd_idx) ? wr_row : mem[rd_idx];
		end
	end

	assign rd_row = rd_row_q;
	assign busy   = clr_busy_q;

endmodule

@@ rtl/core/tcce_update.sv @@
// ---------------------------------------------------------------------------
// tcce_update: per-item connection update
// Takes the registered item and its slot row, applies the open, segment or
// timeout rules, builds the outgoing segment and returns the new row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_update (
	input  tcce_pkg::item_t                    item,
	input  tcce_pkg::row_t                     row,
	input  logic [tcce_pkg::PLEN_W-1:0]        request_len,
	input  logic [tcce_pkg::RC_W-1:0]          max_resends,
	output logic                               wr_en,
	output tcce_pkg::row_t                     new_row,
	output tcce_pkg::res_t                     res
);
	import tcce_pkg::*;

	row_t  r_pre;
	res_t  res_pre;
	logic  do_emit;
	logic  active;
	emit_t em;

	assign active = item.in_range && row.active;

	// State updates that come before the segment is built.
	always_comb begin
		r_pre   = row;
		res_pre = '0;
		wr_en   = 1'b0;
		do_emit = 1'b0;
		unique case (item.operation)
			OP_OPEN: begin
				if (item.in_range) begin
					wr_en                  = 1'b1;
					r_pre.active           = 1'b1;
					r_pre.first_seq        = item.initial_seq;
					r_pre.next_send_seq    = SEQ_W'(item.initial_seq);
					r_pre.oldest_unacked   = SEQ_W'(item.initial_seq);
					r_pre.next_recv_seq    = '0;
					r_pre.conn_flags       = '0;
					r_pre.resend_count     = '0;
					res_pre.send_valid     = 1'b1;
					res_pre.out_seq        = SEQ_W'(item.initial_seq);
					res_pre.out_flags      = TH_SYN;
					res_pre.event_res      = EV_INITIATED;
				end
			end
			OP_SEG: begin
				if (!active) begin
					// Segment for an empty slot is answered with a RST.
					res_pre.send_valid = 1'b1;
					res_pre.out_seq    = item.seg_ack;
					res_pre.out_ack    = item.seg_seq;
					res_pre.out_flags  = TH_RST;
					res_pre.event_res  = EV_RST_REPLY;
				end else begin
					wr_en = 1'b1;
					if ((item.seg_flags & (TH_ACK | TH_RST)) == TH_ACK &&
					    item.seg_ack == SEQ_W'(row.first_seq) + SEQ_W'(1) &&
					    !row.conn_flags[CF_CONN]) begin
						// An ACK of our SYN, without RST, completes the handshake.
						r_pre.next_send_seq        = SEQ_W'(row.first_seq) + SEQ_W'(1);
						r_pre.oldest_unacked       = SEQ_W'(row.first_seq) + SEQ_W'(1);
						r_pre.next_recv_seq        = item.seg_seq + SEQ_W'(1);
						r_pre.conn_flags[CF_CONN]  = 1'b1;
						r_pre.conn_flags[CF_SEND]  = 1'b1;
					end else if (item.seg_data_len != '0) begin
						r_pre.conn_flags[CF_SEND] = 1'b1;
						if (item.seg_end > row.next_recv_seq) begin
							r_pre.next_recv_seq = item.seg_end;
						end
					end
					if ((item.seg_flags & TH_ACK) != '0 &&
					    item.seg_ack > r_pre.oldest_unacked) begin
						r_pre.oldest_unacked = item.seg_ack;
					end
					if ((item.seg_flags & TH_FIN) != '0 &&
					    item.seg_end == r_pre.next_recv_seq &&
					    !r_pre.conn_flags[CF_GFIN]) begin
						r_pre.conn_flags[CF_GFIN] = 1'b1;
						r_pre.conn_flags[CF_SEND] = 1'b1;
						r_pre.next_recv_seq       = r_pre.next_recv_seq + SEQ_W'(1);
					end
					if ((item.seg_flags & TH_RST) != '0) begin
						r_pre.active       = 1'b0;
						res_pre.event_res  = EV_RST_RECV;
						res_pre.slot_freed = 1'b1;
					end else begin
						do_emit = 1'b1;
					end
				end
			end
			OP_TIMEOUT: begin
				if (active) begin
					wr_en = 1'b1;
					if (row.resend_count != RC_MAX) begin
						r_pre.resend_count = row.resend_count + RC_W'(1);
					end
					if (row.resend_count > max_resends) begin
						r_pre.active       = 1'b0;
						res_pre.event_res  = EV_TIMED_OUT;
						res_pre.slot_freed = 1'b1;
					end else begin
						do_emit = 1'b1;
					end
				end
			end
			OP_UNUSED: begin
			end
			default: begin
			end
		endcase
	end

	assign em = emit_seg(r_pre, request_len);

	// Apply the built segment and detect a completed close.
	always_comb begin
		new_row = r_pre;
		res     = res_pre;
		if (do_emit && em.sent) begin
			new_row.conn_flags    = em.conn_flags;
			new_row.next_send_seq = em.next_send_seq;
			res.send_valid        = 1'b1;
			res.out_seq           = em.seq;
			res.out_ack           = em.ack;
			res.out_flags         = em.flags;
			res.out_payload_len   = em.plen;
			if (em.conn_flags[CF_CLOSED]) begin
				new_row.active = 1'b0;
				res.event_res  = EV_COMPLETED;
				res.slot_freed = 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/tcp_client_connection_engine_top.sv @@
// ---------------------------------------------------------------------------
// tcp_client_connection_engine_top: client TCP connection engine
// Keeps a table of client connections and answers each open, received
// segment or retransmit timeout with one segment description and event.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser holds the operation,
//   tdata the slot and segment header summary. m_axis returns exactly one
//   result transaction per command, in order: tuser says whether a segment
//   must be sent, tdata holds its sequence, ack, flags, payload length, the
//   event code and the slot-freed mark.
//   The cfg channel writes request_len (index 0) and max_resends (index 1).
//   It is always ready; write only while the engine is idle (not enforced).
//   A command passes the command register, then the result register. One
//   command is taken every cycle while m_axis does not stall: the slot row
//   is read from the table memory as the command is registered, updated
//   while it is held there, and a row written by one command is forwarded
//   to a command for the same slot that follows it. After reset the table
//   is swept to clear every slot; s_axis_tready stays low during the sweep.
//   When the receiver stalls, the result register and the command register
//   hold, and s_axis_tready drops once both are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_client_connection_engine_top #(
	parameter int NUM_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command stream.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [5:0] slot, [33:6] initial_seq, [39:34] seg_flags, [71:40] seg_seq,
	// [103:72] seg_ack, [119:104] seg_data_len
	input  logic [119:0]                  s_axis_tdata,
	// [1:0] operation
	input  logic [tcce_pkg::OP_W-1:0]     s_axis_tuser,
	// Result stream.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [31:0] out_seq, [63:32] out_ack, [69:64] out_flags,
	// [80:70] out_payload_len, [83:81] event_res, [84] slot_freed, [87:85] zero
	output logic [87:0]                   m_axis_tdata,
	// [0] send_valid
	output logic                          m_axis_tuser,
	// Configuration writes.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcce_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [tcce_pkg::CFG_W-1:0]    cfg_data
);
	import tcce_pkg::*;

	localparam int IDX_W  = $clog2(NUM_SLOTS);
	localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	logic [PLEN_W-1:0] request_len_q;
	logic [RC_W-1:0]   max_resends_q;

	logic              valid_s1;
	item_t             item_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              out_valid_q;
	res_t              out_res_q;

	logic              accept;
	logic              advance;
	logic              busy;
	logic [SLOT_W-1:0] in_slot;
	logic [WIDE_W-1:0] slot_wide;
	logic [IDX_W-1:0]  in_idx;
	item_t             in_item;
	row_t              rd_row;
	row_t              new_row;
	res_t              res;
	logic              upd_wr_en;

	// Unpack the incoming command.
	assign in_slot   = s_axis_tdata[5:0];
	assign slot_wide = WIDE_W'(in_slot);
	assign in_idx    = slot_wide[IDX_W-1:0];

	always_comb begin
		in_item              = '0;
		in_item.operation    = s_axis_tuser;
		in_item.in_range     = (32'(in_slot) < 32'(NUM_SLOTS));
		in_item.initial_seq  = s_axis_tdata[33:6];
		in_item.seg_flags    = s_axis_tdata[39:34];
		in_item.seg_seq      = s_axis_tdata[71:40];
		in_item.seg_ack      = s_axis_tdata[103:72];
		in_item.seg_data_len = s_axis_tdata[119:104];
		in_item.seg_end      = s_axis_tdata[71:40] + SEQ_W'(s_axis_tdata[119:104]);
	end

	// Handshake control.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !busy && (!valid_s1 || advance);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_len_q <= PLEN_W'(30);
			max_resends_q <= RC_W'(5);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_REQUEST_LEN: request_len_q <= cfg_data;
				REG_MAX_RESENDS: max_resends_q <= cfg_data[RC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			idx_s1  <= in_idx;
		end
	end

	tcce_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (valid_s1 && advance && upd_wr_en),
		.wr_idx (idx_s1),
		.wr_row (new_row),
		.rd_en  (accept),
		.rd_idx (in_idx),
		.rd_row (rd_row),
		.busy   (busy)
	);

	tcce_update u_update (
		.item        (item_s1),
		.row         (rd_row),
		.request_len (request_len_q),
		.max_resends (max_resends_q),
		.wr_en       (upd_wr_en),
		.new_row     (new_row),
		.res         (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.send_valid;
	assign m_axis_tdata  = {3'b000, out_res_q.slot_freed, out_res_q.event_res,
	                        out_res_q.out_payload_len, out_res_q.out_flags,
	                        out_res_q.out_ack, out_res_q.out_seq};

	// No command is taken while the table is being cleared.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready)
		else $error("command accepted during table sweep");

	// A stalled command keeps its register contents.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1) && $stable(idx_s1))
		else $error("stalled command changed");

	// A freed slot is reported only with a close, timeout or received RST.
	a_freed_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.slot_freed |->
			out_res_q.event_res == EV_COMPLETED ||
			out_res_q.event_res == EV_TIMED_OUT ||
			out_res_q.event_res == EV_RST_RECV)
		else $error("slot freed with wrong event");

	// A RST reply always carries a segment with the RST flag.
	a_rst_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.event_res == EV_RST_REPLY |->
			out_res_q.send_valid && out_res_q.out_flags == TH_RST)
		else $error("RST reply without RST segment");

endmodule
